### rtl/core/sia_pkg.sv
`timescale 1ns / 1ps

package sia_pkg;

  localparam int SLOT_W = 10;
  localparam int CNT_W  = 11;
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  // request function codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // response status codes
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED    = 2'd1;
  localparam logic [1:0] ST_NEVER_ISSUED = 2'd2;
  localparam logic [1:0] ST_NONE_LIVE    = 2'd3;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot_in;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [1:0]        status;
    logic [CNT_W-1:0]  live_slots;
  } out_rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] slot_capacity;
  } cfg_wr_t;

endpackage

### rtl/core/sia_chan_if.sv
`timescale 1ns / 1ps

interface sia_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sia_ram.sv
`timescale 1ns / 1ps

module sia_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/core/sia_core.sv
`timescale 1ns / 1ps

module sia_core #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  sia_chan_if.sink            in_req,
  sia_chan_if.sink            cfg_wr,
  output logic                res_valid,
  input  logic                res_ready,
  output sia_pkg::out_rsp_t   res
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int CAP_LIM_I = (MAX_SLOTS > sia_pkg::CNT_MAX) ? sia_pkg::CNT_MAX : MAX_SLOTS;
  localparam logic [sia_pkg::CNT_W-1:0] CAP_LIM = sia_pkg::CNT_W'(CAP_LIM_I);

  logic [sia_pkg::CNT_W-1:0] slot_capacity_r;
  logic [sia_pkg::CNT_W-1:0] free_depth_r, free_depth_nxt;
  logic [sia_pkg::CNT_W-1:0] next_fresh_r, next_fresh_nxt;
  logic [sia_pkg::CNT_W-1:0] live_total_r, live_total_nxt;
  logic                      pend_valid_r, pend_valid_nxt;
  logic                      pend_ram_r, pend_ram_nxt;
  sia_pkg::out_rsp_t         pend_rsp_r, pend_rsp_nxt;

  logic                      accept;
  logic [sia_pkg::CNT_W-1:0] cap;
  logic                      stack_ok;
  logic                      fresh_ok;
  logic                      push_ok;
  logic [31:0]               pop_addr_w;
  logic [31:0]               push_addr_w;

  logic                      ram_we;
  logic                      ram_re;
  logic [AW-1:0]             ram_addr;
  logic [sia_pkg::SLOT_W-1:0] ram_wdata;
  logic [sia_pkg::SLOT_W-1:0] ram_rdata;

  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = !pend_valid_r || res_ready;
  assign cfg_wr.ready = 1'b1;

  assign cap         = (slot_capacity_r < CAP_LIM) ? slot_capacity_r : CAP_LIM;
  assign stack_ok    = (free_depth_r != '0) && (32'(free_depth_r) <= MAX_SLOTS);
  assign fresh_ok    = next_fresh_r < cap;
  assign push_ok     = 32'(free_depth_r) < MAX_SLOTS;
  assign pop_addr_w  = 32'(free_depth_r) - 32'd1;
  assign push_addr_w = 32'(free_depth_r);

  always_comb begin
    free_depth_nxt = free_depth_r;
    next_fresh_nxt = next_fresh_r;
    live_total_nxt = live_total_r;
    pend_valid_nxt = pend_valid_r;
    pend_ram_nxt   = pend_ram_r;
    pend_rsp_nxt   = pend_rsp_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = pop_addr_w[AW-1:0];
    ram_wdata      = in_req.data.slot_in;

    if (pend_valid_r && res_ready) begin
      pend_valid_nxt = 1'b0;
    end

    if (accept) begin
      pend_valid_nxt        = 1'b1;
      pend_ram_nxt          = 1'b0;
      pend_rsp_nxt.slot_out = '0;
      pend_rsp_nxt.status   = sia_pkg::ST_OK;
      unique case (in_req.data.func)
        sia_pkg::FN_ALLOC: begin
          if (stack_ok) begin
            // pop: slot comes from the registered stack read in the next cycle
            free_depth_nxt = free_depth_r - 1'b1;
            ram_re         = 1'b1;
            ram_addr       = pop_addr_w[AW-1:0];
            pend_ram_nxt   = 1'b1;
            live_total_nxt = live_total_r + 1'b1;
          end else if (fresh_ok) begin
            pend_rsp_nxt.slot_out = next_fresh_r[sia_pkg::SLOT_W-1:0];
            next_fresh_nxt        = next_fresh_r + 1'b1;
            live_total_nxt        = live_total_r + 1'b1;
          end else begin
            pend_rsp_nxt.status = sia_pkg::ST_EXHAUSTED;
          end
        end
        sia_pkg::FN_FREE: begin
          if ({1'b0, in_req.data.slot_in} >= next_fresh_r) begin
            pend_rsp_nxt.status = sia_pkg::ST_NEVER_ISSUED;
          end else if (live_total_r == '0) begin
            pend_rsp_nxt.status = sia_pkg::ST_NONE_LIVE;
          end else begin
            // push is dropped on a full stack, count still drops
            if (push_ok) begin
              ram_we         = 1'b1;
              ram_addr       = push_addr_w[AW-1:0];
              free_depth_nxt = free_depth_r + 1'b1;
            end
            live_total_nxt = live_total_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
      pend_rsp_nxt.live_slots = live_total_nxt;
    end
  end

  always_comb begin
    res = pend_rsp_r;
    if (pend_ram_r) begin
      res.slot_out = ram_rdata;
    end
  end

  assign res_valid = pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_capacity_r <= '0;
      free_depth_r    <= '0;
      next_fresh_r    <= '0;
      live_total_r    <= '0;
      pend_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        slot_capacity_r <= cfg_wr.data.slot_capacity;
      end
      free_depth_r <= free_depth_nxt;
      next_fresh_r <= next_fresh_nxt;
      live_total_r <= live_total_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ram_r <= pend_ram_nxt;
    pend_rsp_r <= pend_rsp_nxt;
  end

  sia_ram #(
    .WIDTH (sia_pkg::SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

### rtl/core/slot_index_allocator_top.sv
`timescale 1ns / 1ps

// channel  | dir | payload                          | handshake
// ---------+-----+----------------------------------+--------------------
// in_req   | in  | func, slot_in                    | valid / ready
// out_rsp  | out | slot_out, status, live_slots     | valid / ready
// cfg_wr   | in  | slot_capacity                    | valid / ready (always ready)
//
// one request per cycle unless out_rsp stalls; a response passes the pending and output registers
// the free stack lives in a single-port ram with a registered read, so a pop is decided at
// accept time and its slot is picked up from the read data in the next cycle
// one request per cycle is the ram port limit: each request does at most one read or one write
// rst_n is synchronous and clears the counters, capacity and both valid flags; the ram has no clear
// a stalled out_rsp still lets one more request in (held in the pending stage)

module slot_index_allocator_top #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  sia_chan_if.sink   in_req,
  sia_chan_if.source out_rsp,
  sia_chan_if.sink   cfg_wr
);

  // pending stage to output register
  logic              res_valid;
  logic              res_ready;
  sia_pkg::out_rsp_t res;

  logic              out_valid_r, out_valid_nxt;
  sia_pkg::out_rsp_t out_data_r;

  // counters, stack ram and the pending response
  sia_core #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_wr    (cfg_wr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register takes a new response when empty or being drained
  assign res_ready     = !out_valid_r || out_rsp.ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_rsp.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

endmodule

### rtl/core/sia_checker.sv
`timescale 1ns / 1ps

module sia_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sia_pkg::SLOT_W-1:0] slot_out,
  input logic [1:0]                 status,
  input logic [sia_pkg::CNT_W-1:0]  live_slots
);

  logic                      out_acc;
  logic [sia_pkg::CNT_W-1:0] prev_live_r;

  assign out_acc = out_valid && out_ready;

  // live count carried by the last delivered response
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_live_r <= '0;
    end else if (out_acc) begin
      prev_live_r <= live_slots;
    end
  end

  // a failed request grants nothing
  a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (status != sia_pkg::ST_OK) |-> slot_out == '0)
    else $error("failed request carries a nonzero slot");

  // a failed request leaves the live count alone
  a_fail_live_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (status != sia_pkg::ST_OK) |-> live_slots == prev_live_r)
    else $error("failed request changed the live count");

  // a good request moves the live count by exactly one
  a_ok_live_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (status == sia_pkg::ST_OK) |->
      (live_slots == prev_live_r + 1'b1) || (live_slots == prev_live_r - 1'b1))
    else $error("good request moved the live count by other than one");

  // response holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(slot_out) && $stable(status) && $stable(live_slots))
    else $error("stalled response changed");

endmodule

bind slot_index_allocator_top sia_checker u_sia_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .slot_out   (out_rsp.data.slot_out),
  .status     (out_rsp.data.status),
  .live_slots (out_rsp.data.live_slots)
);
